/* hdl/oal_pkg.sv */
// Package for the ordered array list: sizes, operation and status codes,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package oal_pkg;

    localparam int CAPACITY     = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int AW          = $clog2(CAPACITY);      // entry address
    localparam int IW          = $clog2(CAPACITY + 1);  // position / count
    localparam int MODE_BITS   = 3;
    localparam int STATUS_BITS = 2;

    localparam int IN_BITS     = MODE_BITS + IW + KEY_BITS + PAYLOAD_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = KEY_BITS + PAYLOAD_BITS + IW + IW + STATUS_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [MODE_BITS-1:0] MODE_INS_AT   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_INS_LAST = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_DEL_AT   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_DEL_LAST = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_FIND     = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;       // capture the input transaction
        logic exec;       // perform insert / delete / no-op and post result
        logic scan_step;  // advance the find pointer
        logic scan_done;  // post the find result
    } t_dp_cmd;

    typedef struct packed {
        logic is_find;    // held operation is a find
        logic scan_stop;  // find pointer sits on a match or past the last entry
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

/* hdl/oal_ctrl.sv */
// Controller for the ordered array list: idle / run sequencing.
// Depends on oal_pkg.
`default_nettype none

module oal_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  oal_pkg::t_dp_sts i_sts,
    output oal_pkg::t_dp_cmd o_cmd
);
    import oal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_sts.is_find) begin
                    if (!i_sts.scan_stop) begin
                        o_cmd.scan_step = 1'b1;
                    end else if (i_sts.out_free) begin
                        o_cmd.scan_done = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/oal_datapath.sv */
// Datapath for the ordered array list: entry registers with shift paths,
// held operation, find pointer and the result register.
// Depends on oal_pkg.
`default_nettype none

module oal_datapath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  oal_pkg::t_dp_cmd                       i_cmd,
    output oal_pkg::t_dp_sts                       o_sts,
    input  wire [oal_pkg::MODE_BITS-1:0]           i_mode,
    input  wire [oal_pkg::IW-1:0]                  i_position,
    input  wire [oal_pkg::KEY_BITS-1:0]            i_key,
    input  wire [oal_pkg::PAYLOAD_BITS-1:0]        i_payload,
    input  wire                                    i_out_ready,
    output logic                                   o_out_valid,
    output logic [oal_pkg::KEY_BITS-1:0]           o_removed_key,
    output logic [oal_pkg::PAYLOAD_BITS-1:0]       o_removed_payload,
    output logic [oal_pkg::IW-1:0]                 o_found_index,
    output logic [oal_pkg::IW-1:0]                 o_entry_total,
    output logic [oal_pkg::STATUS_BITS-1:0]        o_status
);
    import oal_pkg::*;

    logic [KEY_BITS-1:0]     r_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_pay [CAPACITY];
    logic [KEY_BITS-1:0]     n_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] n_pay [CAPACITY];
    logic [IW-1:0]           r_count;
    logic [IW-1:0]           n_count;

    logic [MODE_BITS-1:0]    r_op_mode;
    logic [IW-1:0]           r_op_pos;
    logic [KEY_BITS-1:0]     r_op_key;
    logic [PAYLOAD_BITS-1:0] r_op_pay;
    logic [IW-1:0]           r_scan;

    logic                    r_out_valid;
    logic [KEY_BITS-1:0]     r_out_rkey;
    logic [PAYLOAD_BITS-1:0] r_out_rpay;
    logic [IW-1:0]           r_out_found;
    logic [IW-1:0]           r_out_total;
    logic [STATUS_BITS-1:0]  r_out_status;

    logic                    is_ins, is_del, is_find;
    logic [IW-1:0]           ins_at, del_at, rd_idx;
    logic                    full, empty, ins_range, del_range, ins_ok, del_ok;
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    scan_hit, scan_end;
    logic [STATUS_BITS-1:0]  op_status;
    logic                    out_wr;

    // decode of the held operation
    always_comb begin
        is_ins    = (r_op_mode == MODE_INS_AT) || (r_op_mode == MODE_INS_LAST);
        is_del    = (r_op_mode == MODE_DEL_AT) || (r_op_mode == MODE_DEL_LAST);
        is_find   = (r_op_mode == MODE_FIND);
        ins_at    = (r_op_mode == MODE_INS_LAST) ? r_count : r_op_pos;
        del_at    = (r_op_mode == MODE_DEL_LAST) ? r_count - IW'(1) : r_op_pos;
        full      = (r_count == IW'(CAPACITY));
        empty     = (r_count == '0);
        ins_range = (ins_at > r_count);
        del_range = (del_at >= r_count);
        ins_ok    = is_ins && !full && !ins_range;
        del_ok    = is_del && !empty && !del_range;

        if (is_ins) begin
            op_status = full ? ST_FULL : (ins_range ? ST_RANGE : ST_OK);
        end else if (is_del) begin
            op_status = empty ? ST_EMPTY : (del_range ? ST_RANGE : ST_OK);
        end else begin
            op_status = ST_OK;
        end
    end

    // single read port, shared by the find pointer and the delete position
    assign rd_idx   = is_find ? r_scan : del_at;
    assign rd_key   = r_key[rd_idx[AW-1:0]];
    assign rd_pay   = r_pay[rd_idx[AW-1:0]];
    assign scan_end = (r_scan >= r_count);
    assign scan_hit = !scan_end && (rd_key == r_op_key);

    assign o_sts.is_find   = is_find;
    assign o_sts.scan_stop = scan_hit || scan_end;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // next entry contents: shift up for insert, down for delete
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_key[i] = r_key[i];
            n_pay[i] = r_pay[i];
        end
        n_count = r_count;
        if (i_cmd.exec && ins_ok) begin
            for (int i = 1; i < CAPACITY; i++) begin
                if (IW'(i) > ins_at) begin
                    n_key[i] = r_key[i-1];
                    n_pay[i] = r_pay[i-1];
                end
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (IW'(i) == ins_at) begin
                    n_key[i] = r_op_key;
                    n_pay[i] = r_op_pay;
                end
            end
            n_count = r_count + IW'(1);
        end else if (i_cmd.exec && del_ok) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IW'(i) >= del_at) begin
                    n_key[i] = r_key[i+1];
                    n_pay[i] = r_pay[i+1];
                end
            end
            n_count = r_count - IW'(1);
        end
    end

    assign out_wr = i_cmd.exec || i_cmd.scan_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= out_wr || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_key[i] <= n_key[i];
            r_pay[i] <= n_pay[i];
        end
        if (i_cmd.load) begin
            r_op_mode <= i_mode;
            r_op_pos  <= i_position;
            r_op_key  <= i_key;
            r_op_pay  <= i_payload;
            r_scan    <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan + IW'(1);
        end
        if (i_cmd.exec) begin
            r_out_rkey   <= del_ok ? rd_key : '0;
            r_out_rpay   <= del_ok ? rd_pay : '0;
            r_out_found  <= '0;
            r_out_total  <= n_count;
            r_out_status <= op_status;
        end else if (i_cmd.scan_done) begin
            r_out_rkey   <= '0;
            r_out_rpay   <= '0;
            r_out_found  <= scan_hit ? r_scan : IW'(CAPACITY);
            r_out_total  <= r_count;
            r_out_status <= ST_OK;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_removed_key     = r_out_rkey;
    assign o_removed_payload = r_out_rpay;
    assign o_found_index     = r_out_found;
    assign o_entry_total     = r_out_total;
    assign o_status          = r_out_status;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(CAPACITY))
        else $error("entry count above capacity");

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_wr |-> (!r_out_valid || i_out_ready))
        else $error("result posted over an untaken result");

    a_total_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_wr |=> (r_out_total == r_count))
        else $error("reported total differs from held count");

    a_count_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("count changed outside an execute cycle");
`endif

endmodule

`default_nettype wire

/* hdl/ordered_array_list.sv */
// Top level of the ordered array list: stream ports, controller and datapath.
// Depends on oal_pkg, oal_ctrl and oal_datapath.
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   56    operation: mode, position, key, payload
// m_axis    out  64    result: removed key/payload, found index, total, status
//
// Insert and delete are accepted in the idle state, then shift the entry
// registers and post the result in the run state. Find steps its pointer
// past the entries before the match, or past every entry when nothing
// matches, then posts; the single shared read port of the entry registers
// checks one entry per cycle. s_axis_tready is high only while idle.
// The result register lets a new transaction be accepted while an earlier
// result waits on m_axis_tready; a stalled result holds the block in its
// posting cycle. Synchronous active-low reset empties the list.

module ordered_array_list (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] mode, [7:3] position, [23:8] key, [55:24] payload
    input  wire [oal_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [15:0] removed_key, [47:16] removed_payload, [52:48] found_index,
    // [57:53] entry_total, [59:58] status, [63:60] zero
    output logic [oal_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import oal_pkg::*;

    localparam int POS_LO = MODE_BITS;
    localparam int KEY_LO = POS_LO + IW;
    localparam int PAY_LO = KEY_LO + KEY_BITS;

    t_dp_cmd                 cmd;
    t_dp_sts                 sts;
    logic [KEY_BITS-1:0]     removed_key;
    logic [PAYLOAD_BITS-1:0] removed_payload;
    logic [IW-1:0]           found_index;
    logic [IW-1:0]           entry_total;
    logic [STATUS_BITS-1:0]  status;

    oal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    oal_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (s_axis_tdata[MODE_BITS-1:0]),
        .i_position        (s_axis_tdata[KEY_LO-1:POS_LO]),
        .i_key             (s_axis_tdata[PAY_LO-1:KEY_LO]),
        .i_payload         (s_axis_tdata[PAY_LO+PAYLOAD_BITS-1:PAY_LO]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_removed_key     (removed_key),
        .o_removed_payload (removed_payload),
        .o_found_index     (found_index),
        .o_entry_total     (entry_total),
        .o_status          (status)
    );

    // pack result, first field lowest, zero fill to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'({status, entry_total, found_index,
                                        removed_payload, removed_key});

endmodule

`default_nettype wire

/* sim/tb_ordered_array_list.sv */
// Self-checking testbench for ordered_array_list: drives list operations on the
// input stream and checks every result against its own model of the list.
// Depends on oal_pkg and the ordered_array_list RTL.

module tb_ordered_array_list;
    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;

    // Mode codes 5 to 7 are spare: the block must treat them as no-ops
    localparam logic [MODE_BITS-1:0] MODE_NOP_5 = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_NOP_6 = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_NOP_7 = 3'd7;

    // Bias of a random phase
    localparam int LEAN_GROW   = 0;
    localparam int LEAN_SHRINK = 1;
    localparam int LEAN_EVEN   = 2;

    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_LEN    = 60;
    localparam int HOLD_CYCLES  = 400;   // long receiver stall
    localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 40;    // covers the longest find
    localparam int RES_PAD      = OUT_TDATA_W - OUT_BITS;

    // Fields of one operation, mode in the lowest bits as on s_axis_tdata
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [KEY_BITS-1:0]     key;
        logic [IW-1:0]           position;
        logic [MODE_BITS-1:0]    mode;
    } list_op_t;

    // Fields of one result, removed_key in the lowest bits as on m_axis_tdata
    typedef struct packed {
        logic [RES_PAD-1:0]      pad;
        logic [STATUS_BITS-1:0]  status;
        logic [IW-1:0]           entry_total;
        logic [IW-1:0]           found_index;
        logic [PAYLOAD_BITS-1:0] removed_payload;
        logic [KEY_BITS-1:0]     removed_key;
    } list_res_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow of the list contents, updated as each transaction is accepted
    logic [KEY_BITS-1:0]     key_store     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] payload_store [CAPACITY];
    int                      live_count = 0;

    list_res_t list_results_due [$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        tx_gaps     = 1'b1;  // sender idles between transactions
    bit        rx_gaps     = 1'b1;  // receiver stalls between transactions
    int        rx_hold     = 0;     // one-off long receiver stall request

    ordered_array_list u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one operation to the shadow list and returns the result due
    function automatic list_res_t apply_list_op(list_op_t op);
        list_res_t r;
        int        at;
        int        i;
        r  = '0;
        at = 0;
        case (op.mode)
            MODE_INS_AT, MODE_INS_LAST: begin
                at = (op.mode == MODE_INS_LAST) ? live_count : int'(op.position);
                // full takes priority over a bad position
                if (live_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (at > live_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = live_count; i > at; i--) begin
                        key_store[i]     = key_store[i-1];
                        payload_store[i] = payload_store[i-1];
                    end
                    key_store[at]     = op.key;
                    payload_store[at] = op.payload;
                    live_count++;
                end
            end
            MODE_DEL_AT, MODE_DEL_LAST: begin
                if (live_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    at = (op.mode == MODE_DEL_LAST) ? live_count - 1 : int'(op.position);
                    if (at >= live_count) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.removed_key     = key_store[at];
                        r.removed_payload = payload_store[at];
                        for (i = at + 1; i < live_count; i++) begin
                            key_store[i-1]     = key_store[i];
                            payload_store[i-1] = payload_store[i];
                        end
                        live_count--;
                    end
                end
            end
            MODE_FIND: begin
                // only occupied entries are searched; no match reports CAPACITY
                r.found_index = IW'(CAPACITY);
                for (i = 0; i < live_count; i++) begin
                    if (key_store[i] == op.key) begin
                        r.found_index = IW'(i);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_total = IW'(live_count);
        return r;
    endfunction

    function automatic list_op_t mk_op(logic [MODE_BITS-1:0] mode, int position,
                                       logic [KEY_BITS-1:0] key,
                                       logic [PAYLOAD_BITS-1:0] payload);
        list_op_t op;
        op.mode     = mode;
        op.position = IW'(position);
        op.key      = key;
        op.payload  = payload;
        return op;
    endfunction

    // Draws one operation; keys come from a narrow pool half the time so that finds
    // hit and duplicate keys build up, positions mostly land in range
    function automatic list_op_t draw_list_op(int lean);
        list_op_t op;
        int       pick;
        int       ins_w;
        int       del_w;
        ins_w = (lean == LEAN_GROW) ? 55 : (lean == LEAN_SHRINK) ? 20 : 37;
        del_w = (lean == LEAN_GROW) ? 20 : (lean == LEAN_SHRINK) ? 55 : 37;
        op.payload  = $urandom();
        op.position = IW'($urandom_range(0, 31));
        if ($urandom_range(0, 9) < 5)
            op.key = $urandom_range(0, 1) ? KEY_BITS'($urandom_range(0, 3))
                                          : ~KEY_BITS'($urandom_range(0, 3));
        else
            op.key = KEY_BITS'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            op.mode = MODE_BITS'(MODE_NOP_5 + $urandom_range(0, 2));
        end else if (pick < 3 + ins_w) begin
            op.mode = $urandom_range(0, 1) ? MODE_INS_AT : MODE_INS_LAST;
            if ($urandom_range(0, 4) != 0)
                op.position = IW'($urandom_range(0, live_count));
        end else if (pick < 3 + ins_w + del_w) begin
            op.mode = $urandom_range(0, 1) ? MODE_DEL_AT : MODE_DEL_LAST;
            if ($urandom_range(0, 4) != 0 && live_count > 0)
                op.position = IW'($urandom_range(0, live_count - 1));
        end else begin
            op.mode = MODE_FIND;
            if (live_count > 0 && $urandom_range(0, 9) < 6)
                op.key = key_store[$urandom_range(0, live_count - 1)];
        end
        return op;
    endfunction

    // Offers one operation and waits for the transaction; valid stays high
    // afterwards so back-to-back operations need no gap
    task automatic send_op(list_op_t op);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= IN_TDATA_W'(op);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        list_results_due.push_back(apply_list_op(op));
    endtask

    // Drops valid and waits for every outstanding result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (list_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, want, seen);
        end
    endtask

    // Result side: stalls at random, honours a long hold request, and checks
    // each accepted transaction against the oldest result due
    initial begin : result_monitor
        list_res_t want;
        list_res_t seen;
        int        gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else begin
                gap = rx_gaps ? $urandom_range(0, 9) : 0;
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            seen = list_res_t'(m_axis_tdata);
            if (list_results_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result expected none, actual 0x%0h", $time, seen);
            end else begin
                want = list_results_due.pop_front();
                check_field("removed_key",     want.removed_key,     seen.removed_key);
                check_field("removed_payload", want.removed_payload, seen.removed_payload);
                check_field("found_index",     want.found_index,     seen.found_index);
                check_field("entry_total",     want.entry_total,     seen.entry_total);
                check_field("status",          want.status,          seen.status);
                check_field("tdata padding",   want.pad,             seen.pad);
            end
        end
    end

    // Watchdog: any cycle with a transaction on either side clears the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Deletes, finds and bad inserts on the freshly reset, empty list
    task automatic test_empty_list();
        send_op(mk_op(MODE_FIND, 0, '0, '0));
        send_op(mk_op(MODE_DEL_LAST, 0, '0, '0));
        send_op(mk_op(MODE_DEL_AT, 0, '0, '0));
        send_op(mk_op(MODE_INS_AT, 1, 16'h0042, 32'h1));
        send_op(mk_op(MODE_INS_AT, 31, '1, '1));
        settle();
    endtask

    // Each operation on a short list, incl. append via position == count
    task automatic test_basic_ops();
        send_op(mk_op(MODE_INS_AT, 0, '1, '1));
        send_op(mk_op(MODE_INS_LAST, 31, '0, '0));
        send_op(mk_op(MODE_INS_AT, 1, 16'h1234, 32'h89AB_CDEF));
        send_op(mk_op(MODE_INS_AT, 3, 16'h00FF, 32'h5555_AAAA));
        send_op(mk_op(MODE_FIND, 0, 16'h1234, '0));
        send_op(mk_op(MODE_FIND, 0, '1, '0));
        send_op(mk_op(MODE_FIND, 0, 16'h5555, '0));
        send_op(mk_op(MODE_DEL_AT, 4, '0, '0));
        send_op(mk_op(MODE_DEL_AT, 16, '0, '0));
        send_op(mk_op(MODE_DEL_AT, 1, '0, '0));
        send_op(mk_op(MODE_DEL_LAST, 0, '0, '0));
        send_op(mk_op(MODE_DEL_AT, 0, '0, '0));
        send_op(mk_op(MODE_DEL_LAST, 0, '0, '0));
        settle();
    endtask

    // Spare mode codes must leave the list alone
    task automatic test_unused_modes();
        send_op(mk_op(MODE_INS_LAST, 0, 16'hBEEF, 32'hCAFE_F00D));
        send_op(mk_op(MODE_NOP_5, 31, '1, '1));
        send_op(mk_op(MODE_NOP_6, $urandom_range(0, 31), KEY_BITS'($urandom()), $urandom()));
        send_op(mk_op(MODE_NOP_7, 0, '0, '0));
        send_op(mk_op(MODE_DEL_LAST, 0, '0, '0));
        settle();
    endtask

    // Fill to capacity with a duplicated key, then hit the full cases
    task automatic test_full_list();
        int n;
        for (n = 0; n < CAPACITY; n++) begin
            if (n == 4 || n == 10)
                send_op(mk_op(MODE_INS_AT, $urandom_range(0, live_count), 16'hA5A5, $urandom()));
            else if (n % 2)
                send_op(mk_op(MODE_INS_LAST, 0, KEY_BITS'($urandom()), $urandom()));
            else
                send_op(mk_op(MODE_INS_AT, $urandom_range(0, live_count),
                              KEY_BITS'($urandom()), $urandom()));
        end
        send_op(mk_op(MODE_INS_LAST, 0, 16'h7777, '1));
        send_op(mk_op(MODE_INS_AT, 0, 16'h7777, '1));
        send_op(mk_op(MODE_INS_AT, 31, 16'h7777, '1));
        send_op(mk_op(MODE_FIND, 0, 16'hA5A5, '0));
        send_op(mk_op(MODE_FIND, 0, key_store[CAPACITY-1], '0));
        send_op(mk_op(MODE_DEL_AT, CAPACITY, '0, '0));
        send_op(mk_op(MODE_DEL_AT, CAPACITY - 1, '0, '0));
        settle();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back-to-back transactions, so the block fills up and stalls its input
    task automatic test_backpressure();
        int n;
        tx_gaps = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (n = 0; n < 24; n++)
            send_op(draw_list_op(LEAN_EVEN));
        tx_gaps = 1'b1;
        settle();
    endtask

    // Phases that lean towards growing, shrinking or neither, with idling
    // switched on and off per phase on each side
    task automatic test_random_mix();
        int done;
        int n;
        int lean;
        for (done = 0; done < RANDOM_ITEMS; done += PHASE_LEN) begin
            lean    = $urandom_range(LEAN_GROW, LEAN_EVEN);
            tx_gaps = ($urandom_range(0, 3) != 0);
            rx_gaps = ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_LEN; n++)
                send_op(draw_list_op(lean));
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        settle();
    endtask

    initial begin : test_sequence
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_basic_ops();
        test_unused_modes();
        test_full_list();
        test_backpressure();
        test_random_mix();
        // catch any stray result after the last one due
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
